### rtl/rde_pkg.sv
// Shared types, constants and the digit-to-ASCII map for radix_digit_emitter.
// No dependencies; imported by rde_dabble, radix_digit_emitter and tb_top.
package rde_pkg;

    localparam int DIG_W      = 4;
    localparam int NUM_SLOTS  = 11;
    localparam int SLOTS_W    = NUM_SLOTS * DIG_W;
    localparam int IDX_W      = 4;
    localparam int VALUE_W    = 32;
    localparam int CHAR_W     = 7;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS = VALUE_W / BITS_PER_STEP;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    localparam logic [1:0] OP_OCT = 2'd0;
    localparam logic [1:0] OP_DEC = 2'd1;
    localparam logic [1:0] OP_HEX = 2'd2;

    localparam logic [CHAR_W-1:0] MINUS_CHAR   = 7'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CHAR    = 7'h30;
    localparam logic [CHAR_W-1:0] LETTER_BASE  = 7'h37;

    typedef logic [SLOTS_W-1:0] slots_t;

    // Map a digit 0..15 to '0'..'9', 'A'..'F'.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIG_W-1:0] d);
        logic [CHAR_W-1:0] ext;
        ext = {{(CHAR_W-DIG_W){1'b0}}, d};
        if (d < 4'd10)
        begin
            digit_char = ZERO_CHAR + ext;
        end
        else
        begin
            digit_char = LETTER_BASE + ext;
        end
    endfunction

endpackage

### rtl/radix_digit_emitter.sv
// Top level of radix_digit_emitter: sequencer, digit store and output register.
// Depends on rde_pkg and rde_dabble.
//
// Usage: drive value and opcode (0 octal, 1 decimal, 2 or 3 hexadecimal) and
// pulse start; the transaction is taken at a rising edge with start high and
// busy low. busy stays high until the final character has been issued.
// Characters come out most significant first, one per cycle, each shown for
// exactly one cycle with strobe high; last marks the final one. Decimal
// negatives lead with '-'. The receiver cannot stall the block.
// Sequence: octal/hex digits are loaded at accept, a leading-zero scan then
// finds the top digit, and the characters follow (1..11 of them). Decimal
// instead loads the magnitude and first passes through a conversion state
// in which the shift-and-add-3 unit folds 4 magnitude bits per cycle into
// BCD; a negative value's '-' goes out during the scan. A new start is
// taken in the cycle the final character is on the outputs. Reset clears
// the sequencer and the strobe; nothing else needs clearing.
module radix_digit_emitter
    import rde_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [VALUE_W-1:0]  value,
    input  logic [1:0]          opcode,
    output logic                strobe,
    output logic [CHAR_W-1:0]   character,
    output logic                last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               neg_reg, neg_next;
    logic               dec_reg, dec_next;
    logic [VALUE_W-1:0] bin_reg, bin_next;
    slots_t             dig_reg, dig_next;
    logic               strobe_reg, strobe_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               last_reg, last_next;

    slots_t             dabble_out;
    slots_t             load_slots;
    logic [IDX_W-1:0]   top_idx;
    logic [DIG_W-1:0]   cur_digit;

    rde_dabble u_dabble (
        .digits_in  (dig_reg),
        .bits_in    (bin_reg[VALUE_W-1 -: BITS_PER_STEP]),
        .digits_out (dabble_out)
    );

    // Octal/hex digits straight from the bit pattern, one per 4-bit slot
    always_comb
    begin
        load_slots = '0;
        case (opcode)
            OP_OCT:
            begin
                for (int i = 0; i < NUM_SLOTS - 1; i++)
                begin
                    load_slots[i*DIG_W +: DIG_W] = {1'b0, value[i*3 +: 3]};
                end
                load_slots[(NUM_SLOTS-1)*DIG_W +: DIG_W] = {2'b00, value[31:30]};
            end
            default:
            begin
                load_slots[VALUE_W-1:0] = value;
            end
        endcase
    end

    // Highest nonzero digit; a negative octal/hex pattern always has a nonzero top
    always_comb
    begin
        top_idx = '0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (dig_reg[i*DIG_W +: DIG_W] != '0)
            begin
                top_idx = IDX_W'(i);
            end
        end
    end

    assign cur_digit = dig_reg[idx_reg*DIG_W +: DIG_W];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        dec_next    = dec_reg;
        bin_next    = bin_reg;
        dig_next    = dig_reg;
        strobe_next = 1'b0;
        char_next   = char_reg;
        last_next   = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    neg_next = value[VALUE_W-1];
                    cnt_next = '0;
                    if (opcode == OP_DEC)
                    begin
                        dec_next   = 1'b1;
                        bin_next   = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
                        dig_next   = '0;
                        state_next = ST_CONV;
                    end
                    else
                    begin
                        dec_next   = 1'b0;
                        dig_next   = load_slots;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_CONV:
            begin
                dig_next = dabble_out;
                bin_next = {bin_reg[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                idx_next = top_idx;
                // issue the sign while the first digit is being set up
                if (dec_reg && neg_reg)
                begin
                    strobe_next = 1'b1;
                    char_next   = MINUS_CHAR;
                    last_next   = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                strobe_next = 1'b1;
                char_next   = digit_char(cur_digit);
                last_next   = (idx_reg == '0);
                if (idx_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        dec_reg  <= dec_next;
        bin_reg  <= bin_next;
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_strobe_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("character issued without a transaction in flight");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("character issued right after the final one");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> strobe && last)
        else $error("busy dropped without the final character");

    a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |-> character != MINUS_CHAR)
        else $error("final character is a sign");

endmodule

### rtl/rde_dabble.sv
// Shift-and-add-3 BCD unit: folds four binary bits into the BCD digit vector.
// Depends on rde_pkg.
module rde_dabble
    import rde_pkg::*;
(
    input  slots_t                   digits_in,
    input  logic [BITS_PER_STEP-1:0] bits_in,
    output slots_t                   digits_out
);

    slots_t acc;
    logic [DIG_W-1:0] d;

    always_comb
    begin
        acc = digits_in;
        d = '0;
        // MSB of the incoming group goes in first
        for (int s = BITS_PER_STEP - 1; s >= 0; s--)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                d = acc[i*DIG_W +: DIG_W];
                if (d >= 4'd5)
                begin
                    acc[i*DIG_W +: DIG_W] = d + 4'd3;
                end
            end
            acc = {acc[SLOTS_W-2:0], bits_in[s]};
        end
        digits_out = acc;
    end

endmodule

### bench/tb_top.sv
// Self-checking testbench for radix_digit_emitter: drives numbers in every base,
// predicts the ASCII character stream and compares it character by character.
// Depends on rde_pkg and the radix_digit_emitter RTL.
module tb_top
    import rde_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int DRAIN_LIMIT = 2000;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              fin;
    } char_exp_t;

    class char_scoreboard;
        char_exp_t pending[$];
        int unsigned errors;

        function new();
            errors = 0;
        endfunction

        function logic [CHAR_W-1:0] glyph_of(logic [3:0] d);
            logic [CHAR_W-1:0] g;
            if (d < 4'd10)
            begin
                g = 7'h30 + {3'b000, d};
            end
            else
            begin
                g = 7'h41 + {3'b000, d} - 7'd10;
            end
            return g;
        endfunction

        // Work out the characters of one accepted number and queue them.
        function void note_number(logic [VALUE_W-1:0] v, logic [1:0] op);
            logic [3:0]         digs[11];
            logic [VALUE_W-1:0] mag;
            logic               neg;
            int                 nd;
            int                 sh;
            int                 maxd;
            char_exp_t          e;
            neg = v[VALUE_W-1];
            nd = 0;
            if (op == OP_DEC)
            begin
                mag = neg ? (32'd0 - v) : v;
                if (neg)
                begin
                    e.ch = MINUS_CHAR;
                    e.fin = 1'b0;
                    pending.push_back(e);
                end
                do
                begin
                    digs[nd] = 4'(mag % 32'd10);
                    nd++;
                    mag = mag / 32'd10;
                end
                while (mag != 0 && nd < 10);
            end
            else
            begin
                sh = (op == OP_OCT) ? 3 : 4;
                maxd = (op == OP_OCT) ? 11 : 8;
                for (int i = 0; i < maxd; i++)
                begin
                    digs[i] = 4'((v >> (sh * i)) & ((op == OP_OCT) ? 32'd7 : 32'd15));
                end
                nd = maxd;
                // drop leading zeros of non-negative numbers, keep one digit
                if (!neg)
                begin
                    while (nd > 1 && digs[nd-1] == 4'd0)
                    begin
                        nd--;
                    end
                end
            end
            while (nd > 0)
            begin
                nd--;
                e.ch = glyph_of(digs[nd]);
                e.fin = (nd == 0);
                pending.push_back(e);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic fin);
            char_exp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual char=%h last=%b",
                         $time, ch, fin);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (ch !== e.ch)
            begin
                $display("%0t: character mismatch: expected %h, actual %h", $time, e.ch, ch);
                errors++;
            end
            if (fin !== e.fin)
            begin
                $display("%0t: last mismatch: expected %b, actual %b", $time, e.fin, fin);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [VALUE_W-1:0]  value;
    logic [1:0]          opcode;
    logic                strobe;
    logic [CHAR_W-1:0]   character;
    logic                last;

    char_scoreboard sb = new();
    int idle_pct;

    radix_digit_emitter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .opcode    (opcode),
        .strobe    (strobe),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            sb.check_char(character, last);
        end
    end

    initial
    begin
        #2_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

    // Hold start high until the transaction is taken; gap cycles of idle first.
    task automatic send_number(logic [VALUE_W-1:0] v, logic [1:0] op);
        int gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < idle_pct)
        begin
            gap++;
        end
        repeat (gap)
        begin
            @(negedge clk);
            start = 1'b0;
        end
        @(negedge clk);
        start = 1'b1;
        value = v;
        opcode = op;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        sb.note_number(v, op);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [VALUE_W-1:0] v;
        case ($urandom_range(5))
            0: v = $urandom;
            1: v = $urandom_range(15);
            2: v = $urandom_range(1000);
            3: v = 32'd0 - $urandom_range(1000, 1);
            4:
            begin
                v = 32'd1 << $urandom_range(31);
                if ($urandom_range(1))
                begin
                    v = 32'd0 - v;
                end
            end
            default: v = $urandom >> $urandom_range(31);
        endcase
        return v;
    endfunction

    function automatic logic [1:0] pick_base();
        int r;
        r = $urandom_range(9);
        if (r < 3)
        begin
            return OP_OCT;
        end
        else if (r < 6)
        begin
            return OP_DEC;
        end
        else if (r < 9)
        begin
            return OP_HEX;
        end
        return OP_SPARE;
    endfunction

    initial
    begin
        logic [VALUE_W-1:0] edge_vals[5];
        logic [1:0]         bases[4];
        int                 phase_pct[4];
        int                 waited;
        rst_n = 1'b0;
        start = 1'b0;
        value = '0;
        opcode = OP_OCT;
        idle_pct = 0;
        edge_vals = '{32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'hFFFF_FFFF};
        bases = '{OP_OCT, OP_DEC, OP_HEX, OP_SPARE};
        phase_pct = '{0, 48, 0, 7};
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // extremes in every base, the spare selector included
        foreach (bases[b])
        begin
            foreach (edge_vals[k])
            begin
                send_number(edge_vals[k], bases[b]);
            end
        end
        send_number(32'd10, OP_DEC);
        send_number(32'd9, OP_DEC);
        send_number(32'h0000_000F, OP_HEX);
        send_number(32'd8, OP_OCT);
        send_number(32'h4000_0000, OP_OCT);

        foreach (phase_pct[p])
        begin
            idle_pct = phase_pct[p];
            repeat (26)
            begin
                send_number(pick_value(), pick_base());
            end
        end
        @(negedge clk);
        start = 1'b0;

        waited = 0;
        while (sb.pending.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (sb.pending.size() != 0)
        begin
            $display("%0t: %0d characters never arrived: expected %h, actual none",
                     $time, sb.pending.size(), sb.pending[0].ch);
            sb.errors++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule
